/* design/scba_pkg.sv */
// ----------------------------------------------------------------------------
// Size-class buffer allocator package
// Field widths, status and operation codes, and the per-class constant tables.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int NUM_CLASSES = 7;
    localparam int CLASS_W     = 3;
    localparam int SLOT_W      = 13;
    localparam int BYTES_W     = 24;
    localparam int BUDGET_W    = 23;
    localparam int STATUS_W    = 2;
    localparam int KB_W        = 14;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 23'd5242880;
    localparam logic [BYTES_W-1:0]  MAX_BYTES    = 24'd8388608;

    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [CLASS_W-1:0]  t_class;
    typedef logic [SLOT_W-1:0]   t_slot;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_TOO_LARGE  = 2'd1;
    localparam t_status ST_NO_BUDGET  = 2'd2;
    localparam t_status ST_NO_SLOT    = 2'd3;

    localparam logic OP_ALLOC  = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    // Class size in bytes.
    function automatic logic [BYTES_W:0] class_bytes(input int c);
        logic [BYTES_W:0] b;
        case (c)
            0:       b = 25'd4096;
            1:       b = 25'd16384;
            2:       b = 25'd65536;
            3:       b = 25'd262144;
            4:       b = 25'd1048576;
            5:       b = 25'd4194304;
            default: b = 25'd8388608;
        endcase
        return b;
    endfunction

    // Class size in kilobytes.
    function automatic logic [KB_W-1:0] class_kb(input t_class c);
        logic [KB_W-1:0] k;
        case (c)
            3'd0:    k = 14'd4;
            3'd1:    k = 14'd16;
            3'd2:    k = 14'd64;
            3'd3:    k = 14'd256;
            3'd4:    k = 14'd1024;
            3'd5:    k = 14'd4096;
            default: k = 14'd8192;
        endcase
        return k;
    endfunction

    // Slots preloaded into each class at reset, before the per-class cap.
    function automatic int preload_count(input int c);
        int n;
        case (c)
            0:       n = 5000;
            1:       n = 1000;
            2:       n = 500;
            3:       n = 200;
            4:       n = 50;
            5:       n = 20;
            default: n = 10;
        endcase
        return n;
    endfunction

    function automatic int capped_count(input int c, input int slots);
        int n;
        n = preload_count(c);
        return (n > slots) ? slots : n;
    endfunction

    // Kilobytes accounted for by the preloaded slots.
    function automatic int preload_kb(input int slots);
        int s;
        s = 0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            s += capped_count(c, slots) * int'(class_kb(t_class'(c)));
        end
        return s;
    endfunction

endpackage

/* design/size_class_buffer_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Size-class buffer allocator
// Seven segregated free stacks held in one stack memory, with per-class depth,
// created-slot counters and a kilobyte total against a programmable budget.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the o_ result ports with o_done high for one cycle, after the execute state
// S_EXEC and in the output state S_OUT, and cannot be held off. busy is high
// for one cycle after acceptance, so a new item can be taken in the cycle its
// predecessor's result is shown. The output state follows the registered read
// of the stack memory that supplies a popped slot. The reset preload of the
// stacks is tracked by a per-class watermark, so the block is ready right after
// reset with no clearing pass. i_cfg_data is written whenever i_cfg_valid is
// high; change it only while no item is in flight.
module size_class_buffer_allocator_unit #(
    parameter int SLOTS_PER_CLASS = 8192
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_op,
    input  logic [scba_pkg::BYTES_W-1:0] i_request_bytes,
    input  logic [scba_pkg::CLASS_W-1:0] i_return_class,
    input  logic [scba_pkg::SLOT_W-1:0]  i_return_slot,
    output logic                         o_done,
    output logic [scba_pkg::STATUS_W-1:0] o_status,
    output logic [scba_pkg::CLASS_W-1:0] o_granted_class,
    output logic [scba_pkg::SLOT_W-1:0]  o_granted_slot,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [scba_pkg::BUDGET_W-1:0] i_cfg_data
);
    import scba_pkg::*;

    localparam int DEP_W     = $clog2(SLOTS_PER_CLASS + 1);
    localparam int IDX_W     = $clog2(SLOTS_PER_CLASS);
    localparam int MEM_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int USED_RESET = preload_kb(SLOTS_PER_CLASS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    function automatic logic [DEP_W-1:0] pre_n(input int c);
        return DEP_W'(capped_count(c, SLOTS_PER_CLASS));
    endfunction

    logic [1:0]          r_state;
    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] r_used_kb;
    logic [DEP_W-1:0]    r_depth   [NUM_CLASSES];
    logic [DEP_W-1:0]    r_created [NUM_CLASSES];
    logic [DEP_W-1:0]    r_wmark   [NUM_CLASSES];

    logic                r_op;
    logic [BYTES_W-1:0]  r_bytes;
    t_class              r_rclass;
    t_slot               r_rslot;

    t_status             r_status;
    t_class              r_gclass;
    t_slot               r_slot;
    logic                r_use_mem;

    t_slot               r_mem [MEM_DEPTH];
    t_slot               r_mem_q;

    // Execute-cycle decode.
    t_class              n_fit_cls;
    logic                n_too_large;
    logic                n_ret_ok;
    t_class              n_cls;
    logic [DEP_W-1:0]    n_depth_cur;
    logic [DEP_W-1:0]    n_created_cur;
    logic [DEP_W-1:0]    n_wmark_cur;
    logic [DEP_W-1:0]    n_pre_n;
    logic [KB_W-1:0]     n_kb;
    logic [BUDGET_W:0]   n_used_sum;
    logic                n_pop;
    logic                n_fresh;
    logic                n_push;
    logic [DEP_W-1:0]    n_idx;
    logic                n_pre_hit;
    t_status             n_status;
    t_slot               n_slot;
    logic [ADDR_W-1:0]   n_addr;

    always_comb begin
        n_fit_cls = t_class'(NUM_CLASSES - 1);
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ({1'b0, r_bytes} <= class_bytes(c)) begin
                n_fit_cls = t_class'(c);
            end
        end
        n_too_large = (r_bytes > MAX_BYTES);
        n_ret_ok    = (r_rclass < t_class'(NUM_CLASSES));

        if (r_op == OP_ALLOC) begin
            n_cls = n_fit_cls;
        end else if (n_ret_ok) begin
            n_cls = r_rclass;
        end else begin
            n_cls = '0;
        end

        n_depth_cur   = r_depth[n_cls];
        n_created_cur = r_created[n_cls];
        n_wmark_cur   = r_wmark[n_cls];
        n_pre_n       = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (n_cls == t_class'(c)) begin
                n_pre_n = pre_n(c);
            end
        end
        n_kb       = class_kb(n_cls);
        n_used_sum = {1'b0, r_used_kb} + (BUDGET_W + 1)'(n_kb);

        n_pop    = 1'b0;
        n_fresh  = 1'b0;
        n_push   = 1'b0;
        n_status = ST_OK;
        n_slot   = '0;
        n_idx    = n_depth_cur;

        if (r_op == OP_ALLOC) begin
            if (n_too_large) begin
                n_status = ST_TOO_LARGE;
            end else if (n_depth_cur != '0) begin
                n_pop = 1'b1;
                n_idx = n_depth_cur - DEP_W'(1);
            end else if (n_used_sum >= {1'b0, r_budget}) begin
                n_status = ST_NO_BUDGET;
            end else if (n_created_cur >= DEP_W'(SLOTS_PER_CLASS)) begin
                n_status = ST_NO_SLOT;
            end else begin
                n_fresh = 1'b1;
                n_slot  = SLOT_W'(n_created_cur);
            end
        end else begin
            n_push = n_ret_ok && (n_depth_cur < DEP_W'(SLOTS_PER_CLASS));
        end

        // Entries below the watermark still hold their reset preload.
        n_pre_hit = n_pop && (n_idx < n_wmark_cur);
        if (n_pre_hit) begin
            n_slot = SLOT_W'(n_pre_n - n_depth_cur);
        end

        n_addr = ADDR_W'(n_cls) * ADDR_W'(SLOTS_PER_CLASS) + ADDR_W'(n_idx[IDX_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            if (n_push) begin
                r_mem[n_addr] <= r_rslot;
            end
            if (n_pop) begin
                r_mem_q <= r_mem[n_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_budget  <= BUDGET_RESET;
            r_used_kb <= BUDGET_W'(USED_RESET);
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_depth[c]   <= pre_n(c);
                r_created[c] <= pre_n(c);
                r_wmark[c]   <= pre_n(c);
            end
        end else begin
            if (i_cfg_valid) begin
                r_budget <= i_cfg_data;
            end
            case (r_state)
                S_IDLE, S_OUT: begin
                    if (start) begin
                        r_state  <= S_EXEC;
                        r_op     <= i_op;
                        r_bytes  <= i_request_bytes;
                        r_rclass <= i_return_class;
                        r_rslot  <= i_return_slot;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EXEC: begin
                    r_state   <= S_OUT;
                    r_status  <= n_status;
                    r_gclass  <= (r_op == OP_ALLOC && !n_too_large) ? n_cls : '0;
                    r_slot    <= n_slot;
                    r_use_mem <= n_pop && !n_pre_hit;
                    if (n_pop) begin
                        r_depth[n_cls] <= n_idx;
                    end
                    if (n_push) begin
                        r_depth[n_cls] <= n_depth_cur + DEP_W'(1);
                        if (n_depth_cur < n_wmark_cur) begin
                            r_wmark[n_cls] <= n_depth_cur;
                        end
                    end
                    if (n_fresh) begin
                        r_created[n_cls] <= n_created_cur + DEP_W'(1);
                        r_used_kb        <= n_used_sum[BUDGET_W-1:0];
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state == S_EXEC);
    assign o_done          = (r_state == S_OUT);
    assign o_status        = r_status;
    assign o_granted_class = r_gclass;
    assign o_granted_slot  = r_use_mem ? r_mem_q : r_slot;
    assign o_cfg_ready     = 1'b1;

    // An accepted item passes through busy and then shows its result on o_done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 o_done)
        else $error("result not produced two cycles after acceptance");

    // A result is never shown in two consecutive cycles.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // Oversized requests grant nothing.
    a_too_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_TOO_LARGE) |->
            (o_granted_class == '0 && o_granted_slot == '0))
        else $error("too_large result carries a grant");

    // Failed allocations hand out slot zero.
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_NO_BUDGET || o_status == ST_NO_SLOT)) |->
            (o_granted_slot == '0))
        else $error("failed allocation carries a slot");

    // The kilobyte total never goes down.
    a_used_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_used_kb >= $past(r_used_kb)))
        else $error("kilobyte total decreased");

endmodule
